### rtl/core/at_response_line_classifier_top_assert.svh
// Assertion macros shared by the response line classifier checkers.
// Depends on nothing; included by the checker file.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ARC_CHK_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("arc check failed");

// Next-cycle implication, off during reset.
`define ARC_CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("arc check failed");

// Next-cycle implication that also holds across reset.
`define ARC_CHK_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("arc check failed");

`endif

### rtl/core/arc_pkg.sv
// Shared types and constants for the response line classifier.
// No dependencies; imported by every core module.
package arc_pkg;

  localparam int KW_COUNT   = 8;
  localparam int KW_MAX_LEN = 8;
  localparam int LEN_W      = 7;

  typedef logic [3:0] arc_kind_t;

  localparam arc_kind_t KIND_OK   = 4'd0;
  localparam arc_kind_t KIND_DEC  = 4'd2;
  localparam arc_kind_t KIND_NONE = 4'd8;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Keywords right-aligned: last character in bits 7..0.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0000_4F4B,  // OK
    64'h0000_0045_5252_4F52,  // ERROR
    64'h0000_0000_4E65_756C,  // vendor banner
    64'h002B_4345_5245_473A,  // +CEREG:
    64'h002B_4E50_494E_473A,  // +NPING:
    64'h2B4E_534F_4E4D_493A,  // +NSONMI:
    64'h0000_2B4E_4E4D_493A,  // +NNMI:
    64'h0000_2B4E_534D_493A   // +NSMI:
  };

  localparam logic [63:0] KW_MASK [KW_COUNT] = '{
    64'h0000_0000_0000_FFFF,
    64'h0000_00FF_FFFF_FFFF,
    64'h0000_0000_FFFF_FFFF,
    64'h00FF_FFFF_FFFF_FFFF,
    64'h00FF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF
  };

  typedef struct packed {
    arc_kind_t        kind;
    logic [LEN_W-1:0] length;
  } arc_event_t;

  typedef struct packed {
    logic       push;
    arc_event_t ev;
  } arc_push_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } arc_qstat_t;

endpackage

### rtl/core/arc_if.sv
// Valid/ready channel interfaces: received bytes in, classified lines out.
// No dependencies.
interface arc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface arc_line_if;
  logic       valid;
  logic       ready;
  logic [3:0] line_kind;
  logic [7:0] balance;
  logic [6:0] line_length;

  modport source (output valid, output line_kind, output balance, output line_length,
                  input ready);
  modport sink   (input valid, input line_kind, input balance, input line_length,
                  output ready);
endinterface

### rtl/core/arc_front.sv
// Front end: frames CR LF lines, tracks keyword hits, emits one event per line.
// Depends on arc_pkg and arc_byte_if.
module arc_front import arc_pkg::*; #(
  parameter int LINE_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  arc_byte_if.sink   rx,
  input  arc_qstat_t qstat,
  output arc_push_t  push
);

  localparam int FILL_W = $clog2(LINE_MAX + 1);
  localparam int HIST_W = (KW_MAX_LEN - 1) * 8;

  logic [HIST_W-1:0]   hist;
  logic [KW_COUNT-1:0] flags;
  logic [FILL_W-1:0]   fill;
  logic                last_cr;

  logic                take;
  logic                over;
  logic [HIST_W-1:0]   hist_base;
  logic [KW_COUNT-1:0] flags_base;
  logic [FILL_W-1:0]   fill_base;
  logic                cr_base;
  logic [63:0]         window;
  logic [KW_COUNT-1:0] hits;
  logic [KW_COUNT-1:0] flags_now;
  logic [FILL_W-1:0]   fill_now;
  logic [FILL_W-1:0]   len_full;
  logic                line_end;
  arc_kind_t           kind;

  assign rx.ready = !qstat.full;
  assign take     = rx.valid && rx.ready;

  always_comb begin
    // a full buffer drops the line before this byte goes in
    over       = (fill >= FILL_W'(LINE_MAX));
    hist_base  = over ? '0 : hist;
    flags_base = over ? '0 : flags;
    fill_base  = over ? '0 : fill;
    cr_base    = over ? 1'b0 : last_cr;

    window = {hist_base, rx.rx_byte};
    for (int k = 0; k < KW_COUNT; k++) begin
      hits[k] = (((window ^ KW_TEXT[k]) & KW_MASK[k]) == 64'd0);
    end
    flags_now = flags_base | hits;
    fill_now  = fill_base + FILL_W'(1);
    len_full  = fill_now - FILL_W'(2);
    line_end  = cr_base && (rx.rx_byte == CH_LF);

    kind = KIND_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags_now[k]) begin
        kind = arc_kind_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      flags   <= '0;
      fill    <= '0;
      last_cr <= 1'b0;
    end else if (take) begin
      if (line_end) begin
        hist    <= '0;
        flags   <= '0;
        fill    <= '0;
        last_cr <= 1'b0;
      end else begin
        hist    <= window[HIST_W-1:0];
        flags   <= flags_now;
        fill    <= fill_now;
        last_cr <= (rx.rx_byte == CH_CR);
      end
    end
  end

  assign push.push      = take && line_end;
  assign push.ev.kind   = kind;
  assign push.ev.length = LEN_W'(len_full);

endmodule

### rtl/core/arc_queue.sv
// Short event queue between front and back ends.
// Depends on arc_pkg.
module arc_queue import arc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  arc_push_t  push,
  input  logic       pop,
  output arc_qstat_t stat,
  output arc_event_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  arc_event_t     slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.not_empty = (count != '0);
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push.push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/arc_back.sv
// Back end: applies the balance update and holds the result for the sink.
// Depends on arc_pkg and arc_line_if.
module arc_back import arc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arc_qstat_t qstat,
  input  arc_event_t head,
  output logic       pop,
  arc_line_if.source line
);

  logic             out_valid;
  arc_kind_t        kind_q;
  logic [LEN_W-1:0] len_q;
  logic [7:0]       bal;
  logic [7:0]       bal_next;

  assign pop = qstat.not_empty && (!out_valid || line.ready);

  always_comb begin
    priority if (head.kind == KIND_OK) begin
      bal_next = bal + 8'd1;
    end else if (head.kind == KIND_DEC) begin
      bal_next = bal - 8'd1;
    end else begin
      bal_next = bal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bal       <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      bal       <= bal_next;
    end else if (line.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_q <= head.kind;
      len_q  <= head.length;
    end
  end

  // balance only moves on a load, so the counter itself is the payload
  assign line.valid       = out_valid;
  assign line.line_kind   = kind_q;
  assign line.balance     = bal;
  assign line.line_length = len_q;

endmodule

### rtl/core/at_response_line_classifier_top.sv
// A line's event enters the event queue with its LF, then the output register on a pop.
// Throughput: one byte per cycle; rx.ready drops only when the event queue is full,
// which happens only while line.ready stays low.
// Reset (synchronous, rst high) clears line framing, keyword flags, the queue,
// the output valid flag and the balance counter.
// Depends on arc_pkg, arc_if, arc_front, arc_queue, arc_back.
module at_response_line_classifier_top import arc_pkg::*; #(
  parameter int LINE_MAX    = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  arc_byte_if.sink   rx,
  arc_line_if.source line
);

  arc_push_t  push;
  arc_qstat_t qstat;
  arc_event_t head;
  logic       pop;

  arc_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .qstat(qstat),
    .push (push)
  );

  arc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (pop),
    .stat(qstat),
    .head(head)
  );

  arc_back u_back (
    .clk  (clk),
    .rst  (rst),
    .qstat(qstat),
    .head (head),
    .pop  (pop),
    .line (line)
  );

endmodule

### rtl/core/arc_checker.sv
// Port-level checks on the classifier result channel, bound to the top level.
// Depends on arc_pkg and at_response_line_classifier_top_assert.svh.
`include "at_response_line_classifier_top_assert.svh"

module arc_checker import arc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [3:0] line_kind,
  input logic [7:0] balance,
  input logic [6:0] line_length
);

  logic [7:0] prev_bal;
  logic [7:0] exp_bal;

  // balance of the last delivered transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_bal <= '0;
    end else if (valid && ready) begin
      prev_bal <= balance;
    end
  end

  assign exp_bal = (line_kind == KIND_OK)  ? prev_bal + 8'd1 :
                   (line_kind == KIND_DEC) ? prev_bal - 8'd1 : prev_bal;

  `ARC_CHK_IMPL(a_kind_range, clk, rst, valid, line_kind <= KIND_NONE)
  `ARC_CHK_IMPL(a_balance_step, clk, rst, valid, balance == exp_bal)
  `ARC_CHK_NEXT(a_stall_hold, clk, rst, valid && !ready, valid && $stable(line_kind) && $stable(balance) && $stable(line_length))
  `ARC_CHK_ALWAYS(a_reset_idle, clk, rst, !valid)

endmodule

bind at_response_line_classifier_top arc_checker u_arc_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (line.valid),
  .ready      (line.ready),
  .line_kind  (line.line_kind),
  .balance    (line.balance),
  .line_length(line.line_length)
);
